### hw/rtl/etc2_rgb_block_decoder_macros.svh
// Assertion macros used by the checker file.
`ifndef ETC2_RGB_BLOCK_DECODER_MACROS_SVH
`define ETC2_RGB_BLOCK_DECODER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ETC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ETC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/etc2_pkg.sv
package etc2_pkg;

    typedef enum logic [1:0] {
        FMT_ETC1  = 2'd0,
        FMT_ETC2  = 2'd1,
        FMT_PUNCH = 2'd2,
        FMT_RSVD  = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        MODE_BASE   = 2'd0,
        MODE_T      = 2'd1,
        MODE_H      = 2'd2,
        MODE_PLANAR = 2'd3
    } mode_t;

    // Classified block handed from the front part to the back part.
    typedef struct packed {
        logic [63:0] word;
        mode_t       mode;
        logic        diff;
        logic        transp;
    } job_t;

    function automatic logic [7:0] mod_val(input logic [2:0] code, input logic lsb);
        logic [7:0] v;
        begin
            v = 8'd0;
            unique case ({code, lsb})
                4'h0: v = 8'd2;   4'h1: v = 8'd8;
                4'h2: v = 8'd5;   4'h3: v = 8'd17;
                4'h4: v = 8'd9;   4'h5: v = 8'd29;
                4'h6: v = 8'd13;  4'h7: v = 8'd42;
                4'h8: v = 8'd18;  4'h9: v = 8'd60;
                4'ha: v = 8'd24;  4'hb: v = 8'd80;
                4'hc: v = 8'd33;  4'hd: v = 8'd106;
                4'he: v = 8'd47;  4'hf: v = 8'd183;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [6:0] dist_val(input logic [2:0] di);
        logic [6:0] v;
        begin
            v = 7'd0;
            unique case (di)
                3'd0: v = 7'd3;  3'd1: v = 7'd6;  3'd2: v = 7'd11; 3'd3: v = 7'd16;
                3'd4: v = 7'd23; 3'd5: v = 7'd32; 3'd6: v = 7'd41; 3'd7: v = 7'd64;
                default: v = 7'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] clamp10(input logic signed [10:0] v);
        logic [7:0] r;
        begin
            if (v < 0) r = 8'd0;
            else if (v > 11'sd255) r = 8'd255;
            else r = v[7:0];
            return r;
        end
    endfunction

endpackage

### hw/rtl/etc2_rgb_block_decoder.sv
// ETC1 / ETC2 RGB / punch-through block decoder.
// s_axis: one 64-bit block per transaction, first block byte in bits 63..56.
// m_axis: sixteen pixel transactions per block in raster order; tlast marks
//   the sixteenth pixel. tdata holds pixel_index, red, green, blue, alpha.
// cfg: format_mode write channel (0 ETC1, 1 ETC2 RGB, 2 punch-through); the user
//   must write it only while the block is idle, which the block does not enforce.
// A block reaches m_axis through the queue, block state and output registers.
// Throughput: one pixel per cycle while m_axis_tready is high; the pixel
//   counter of the back part, stepping once per emitted pixel, sets this.
// A two-entry queue sits between the classifier and the pixel generator,
//   so blocks are taken while the previous block's pixels stream out.
// Reset clears the queue, the pixel counter and the output valid flag, and
//   sets format_mode to 1 (ETC2 RGB).
// With m_axis_tready low and a pixel waiting, the output register holds it, the
//   generator stalls, and s_axis_tready drops once the queue fills.
module etc2_rgb_block_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // block_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // pixel_index[3:0], red, green, blue, alpha
    output logic        m_axis_tlast,   // last_pixel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data        // format_mode
);

    etc2_pkg::fmt_t fmt_reg;
    etc2_pkg::job_t job;
    logic job_valid, job_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) fmt_reg <= etc2_pkg::FMT_ETC2;
        else if (cfg_valid) fmt_reg <= etc2_pkg::fmt_t'(cfg_data);
    end

    etc2_front u_front (
        .aclk(aclk), .aresetn(aresetn), .fmt(fmt_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_word(s_axis_tdata),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    etc2_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .px_valid(m_axis_tvalid), .px_ready(m_axis_tready),
        .px_data(m_axis_tdata), .px_last(m_axis_tlast)
    );

endmodule

### hw/rtl/etc2_front.sv
module etc2_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  etc2_pkg::fmt_t    fmt,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       in_word,
    output logic              job_valid,
    input  logic              job_ready,
    output etc2_pkg::job_t    job
);

    etc2_pkg::job_t cls;
    logic signed [9:0] r_s, g_s, b_s;
    logic diffbit, etc1, pt;

    // Two-entry queue between classification and pixel generation.
    etc2_pkg::job_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    function automatic logic signed [9:0] ovf(input logic [7:0] v);
        return $signed({2'b00, v & 8'hf8}) + $signed({5'b0, v[1:0], 3'b000})
            - $signed({4'b0, v[2], 5'b00000});
    endfunction

    always_comb begin
        diffbit = in_word[33];
        etc1 = (fmt == etc2_pkg::FMT_ETC1);
        pt = (fmt == etc2_pkg::FMT_PUNCH);
        r_s = ovf(in_word[63:56]);
        g_s = ovf(in_word[55:48]);
        b_s = ovf(in_word[47:40]);
        cls.word = in_word;
        cls.transp = 1'b0;
        cls.diff = diffbit;
        cls.mode = etc2_pkg::MODE_BASE;
        if (!etc1 && (pt || diffbit)) begin
            cls.transp = pt && !diffbit;
            cls.diff = 1'b1;
            if (r_s < 0 || r_s > 10'sd255) cls.mode = etc2_pkg::MODE_T;
            else if (g_s < 0 || g_s > 10'sd255) cls.mode = etc2_pkg::MODE_H;
            else if (b_s < 0 || b_s > 10'sd255) cls.mode = etc2_pkg::MODE_PLANAR;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = job_valid && job_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= cls;
    end

endmodule

### hw/rtl/etc2_back.sv
module etc2_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  etc2_pkg::job_t  job,
    output logic            px_valid,
    input  logic            px_ready,
    output logic [39:0]     px_data,
    output logic            px_last
);

    // Per-block precomputed colors, loaded when a job is taken.
    logic [63:0]     w_reg;
    etc2_pkg::mode_t mode_reg;
    logic            transp_reg;
    logic [7:0]      c_reg [2][3];
    logic [7:0]      paint_reg [4][3];
    logic            busy_reg;
    logic [3:0]      pix_reg;

    logic [7:0]      c_n [2][3];
    logic [7:0]      paint_n [4][3];
    logic [7:0]      d [8];

    logic            out_v_reg;
    logic [39:0]     out_d_reg;
    logic            out_l_reg;

    logic            adv;
    logic            load;
    logic [7:0]      pr, pg, pb, pa;

    always_comb begin
        for (int i = 0; i < 8; i++) d[i] = job.word[63 - 8*i -: 8];
    end

    // Base colors, T/H paint colors and planar colors for the incoming job.
    always_comb begin
        logic [7:0] v, b0, b1;
        logic [3:0] r1, g1, b1h, r2, g2, b2h;
        logic [2:0] di;
        logic [6:0] th_dist;
        logic signed [10:0] t;
        r1 = 4'd0;
        g1 = 4'd0;
        b1h = 4'd0;
        r2 = 4'd0;
        g2 = 4'd0;
        b2h = 4'd0;
        di = 3'd0;
        th_dist = 7'd0;
        t = 11'sd0;
        for (int ch = 0; ch < 3; ch++) begin
            v = d[ch];
            b0 = v & 8'hf8;
            b1 = (b0 + {3'b0, v[1:0], 3'b000} - {2'b0, v[2], 5'b0}) & 8'hf8;
            if (job.diff) begin
                c_n[0][ch] = b0 | {5'b0, b0[7:5]};
                c_n[1][ch] = b1 | {5'b0, b1[7:5]};
            end else begin
                c_n[0][ch] = {v[7:4], v[7:4]};
                c_n[1][ch] = {v[3:0], v[3:0]};
            end
        end
        for (int k = 0; k < 4; k++)
            for (int ch = 0; ch < 3; ch++) paint_n[k][ch] = 8'd0;
        if (job.mode == etc2_pkg::MODE_T) begin
            r1 = {d[0][4:3], d[0][1:0]};
            th_dist = etc2_pkg::dist_val({d[3][3:2], d[3][0]});
            paint_n[0][0] = {r1, r1};
            paint_n[0][1] = {d[1][7:4], d[1][7:4]};
            paint_n[0][2] = {d[1][3:0], d[1][3:0]};
            c_n[1][0] = {d[2][7:4], d[2][7:4]};
            c_n[1][1] = {d[2][3:0], d[2][3:0]};
            c_n[1][2] = {d[3][7:4], d[3][7:4]};
            for (int ch = 0; ch < 3; ch++) begin
                t = $signed({3'b0, c_n[1][ch]}) + $signed({4'b0, th_dist});
                paint_n[1][ch] = etc2_pkg::clamp10(t);
                paint_n[2][ch] = c_n[1][ch];
                t = $signed({3'b0, c_n[1][ch]}) - $signed({4'b0, th_dist});
                paint_n[3][ch] = etc2_pkg::clamp10(t);
            end
        end else if (job.mode == etc2_pkg::MODE_H) begin
            r1 = d[0][6:3];
            g1 = {d[0][2:0], d[1][4]};
            b1h = {d[1][3], d[1][1:0], d[2][7]};
            r2 = d[2][6:3];
            g2 = {d[2][2:0], d[3][7]};
            b2h = d[3][6:3];
            di = {d[3][2], d[3][0], 1'b0};
            if ({r1, g1, b1h} >= {r2, g2, b2h}) di = di + 3'd1;
            th_dist = etc2_pkg::dist_val(di);
            c_n[0][0] = {r1, r1}; c_n[0][1] = {g1, g1}; c_n[0][2] = {b1h, b1h};
            c_n[1][0] = {r2, r2}; c_n[1][1] = {g2, g2}; c_n[1][2] = {b2h, b2h};
            for (int k = 0; k < 2; k++)
                for (int ch = 0; ch < 3; ch++) begin
                    t = $signed({3'b0, c_n[k][ch]}) + $signed({4'b0, th_dist});
                    paint_n[2*k][ch] = etc2_pkg::clamp10(t);
                    t = $signed({3'b0, c_n[k][ch]}) - $signed({4'b0, th_dist});
                    paint_n[2*k+1][ch] = etc2_pkg::clamp10(t);
                end
        end else if (job.mode == etc2_pkg::MODE_PLANAR) begin
            // Origin, horizontal and vertical colors, stored in paint rows 0..2.
            paint_n[0][0] = {d[0][6:1], d[0][6:5]};
            paint_n[0][1] = {d[0][0], d[1][6:1], d[0][0]};
            paint_n[0][2] = {d[1][0], d[2][4:3], d[2][1:0], d[3][7], d[1][0], d[2][4]};
            paint_n[1][0] = {d[3][6:2], d[3][0], d[3][6:5]};
            paint_n[1][1] = {d[4][7:1], d[4][7]};
            paint_n[1][2] = {d[4][0], d[5][7:3], d[4][0], d[5][7]};
            paint_n[2][0] = {d[5][2:0], d[6][7:5], d[5][2:1]};
            paint_n[2][1] = {d[6][4:0], d[7][7:6], d[6][4]};
            paint_n[2][2] = {d[7][5:0], d[7][5:4]};
        end
    end

    // Per-pixel color from the stored block state.
    always_comb begin
        logic [3:0] ci;
        logic [1:0] x, y;
        logic lsb, msb, s;
        logic [2:0] code;
        logic signed [10:0] m, t;
        logic signed [12:0] sp;
        logic [7:0] ch_o [3];
        x = pix_reg[1:0];
        y = pix_reg[3:2];
        ci = {x, y};
        lsb = w_reg[{2'b00, ci}];
        msb = w_reg[{2'b01, ci}];
        s = 1'b0;
        code = 3'd0;
        m = 11'sd0;
        t = 11'sd0;
        sp = 13'sd0;
        pa = 8'd255;
        for (int ch = 0; ch < 3; ch++) ch_o[ch] = 8'd0;
        unique case (mode_reg)
            etc2_pkg::MODE_BASE: begin
                s = w_reg[32] ? y[1] : x[1];
                code = s ? w_reg[36:34] : w_reg[39:37];
                m = $signed({3'b0, etc2_pkg::mod_val(code, lsb)});
                if (transp_reg && !lsb) begin
                    m = 11'sd0;
                    if (msb) pa = 8'd0;
                end
                if (msb) m = -m;
                for (int ch = 0; ch < 3; ch++) begin
                    t = $signed({3'b0, c_reg[s][ch]}) + m;
                    ch_o[ch] = etc2_pkg::clamp10(t);
                end
            end
            etc2_pkg::MODE_T, etc2_pkg::MODE_H: begin
                for (int ch = 0; ch < 3; ch++) ch_o[ch] = paint_reg[{msb, lsb}][ch];
                if (transp_reg && msb && !lsb) pa = 8'd0;
            end
            etc2_pkg::MODE_PLANAR: begin
                for (int ch = 0; ch < 3; ch++) begin
                    sp = $signed({3'b0, x}) * ($signed({5'b0, paint_reg[1][ch]})
                          - $signed({5'b0, paint_reg[0][ch]}))
                       + $signed({3'b0, y}) * ($signed({5'b0, paint_reg[2][ch]})
                          - $signed({5'b0, paint_reg[0][ch]}))
                       + $signed({3'b0, paint_reg[0][ch], 2'b00}) + 13'sd2;
                    ch_o[ch] = etc2_pkg::clamp10(11'(sp >>> 2));
                end
            end
            default: ;
        endcase
        pr = ch_o[0];
        pg = ch_o[1];
        pb = ch_o[2];
    end

    assign adv = busy_reg && (!out_v_reg || px_ready);
    assign load = job_valid && job_ready;
    assign job_ready = !busy_reg || (adv && pix_reg == 4'd15);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pix_reg <= 4'd0;
            out_v_reg <= 1'b0;
        end else begin
            if (adv) pix_reg <= pix_reg + 4'd1;
            if (load) begin
                busy_reg <= 1'b1;
                pix_reg <= 4'd0;
            end else if (adv && pix_reg == 4'd15) begin
                busy_reg <= 1'b0;
            end
            if (adv) out_v_reg <= 1'b1;
            else if (px_ready) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            w_reg <= job.word;
            mode_reg <= job.mode;
            transp_reg <= job.transp;
            c_reg <= c_n;
            paint_reg <= paint_n;
        end
        if (adv) begin
            out_d_reg <= {4'd0, pa, pb, pg, pr, pix_reg};
            out_l_reg <= (pix_reg == 4'd15);
        end
    end

    assign px_valid = out_v_reg;
    assign px_data = out_d_reg;
    assign px_last = out_l_reg;

endmodule

### hw/rtl/etc2_checker.sv
`include "etc2_rgb_block_decoder_macros.svh"

module etc2_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `ETC_ASSERT_IMPL(a_last_idx, aclk, aresetn, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[3:0] == 4'd15), "tlast does not match pixel 15")

    `ETC_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_axis_tvalid && m_axis_tready && m_axis_tvalid
        && !m_axis_tlast, !m_axis_tvalid || m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1,
        "pixel index skipped")

    `ETC_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled pixel changed")

endmodule

bind etc2_rgb_block_decoder etc2_checker u_etc2_checker (
    .aclk(aclk), .aresetn(aresetn), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_PER_FMT = 31;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    etc2_rgb_block_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    logic [63:0]     block_q[$];
    pixel_t          pixel_q[$];
    etc2_pkg::fmt_t  cur_fmt;
    int              err_count;
    int              idle_cycles;
    int              send_gap;
    int              recv_gap;
    int              img[16][4];

    etc2_pkg::fmt_t fmt_seq[6] = '{etc2_pkg::FMT_ETC1, etc2_pkg::FMT_ETC2,
                                   etc2_pkg::FMT_PUNCH, etc2_pkg::FMT_RSVD,
                                   etc2_pkg::FMT_PUNCH, etc2_pkg::FMT_ETC2};
    logic [63:0] directed[12] = '{
        64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
        64'h1234_5678_9abc_def0, 64'hfbfb_fb02_a5c3_3c5a,
        64'hfb5c_a3b6_f0f0_3c3c, 64'h03fb_21c6_5555_aaaa,
        64'h7bfb_0183_0f0f_f0f0, 64'h0000_fbfe_ffff_0000,
        64'hfcfe_0403_ffff_ffff, 64'h8080_8000_ffff_0000,
        64'hfb00_0001_ffff_0000, 64'h4080_c0e5_1234_abcd};

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int clamp8(input int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    // Column-major position in the index bits maps to raster position.
    function automatic void paint_px(input int col, input int r, input int g, input int b,
                                     input int a);
        int p;
        p = (col & 3) * 4 + (col >> 2);
        img[p][0] = clamp8(r);
        img[p][1] = clamp8(g);
        img[p][2] = clamp8(b);
        img[p][3] = clamp8(a);
    endfunction

    function automatic void decode_base(input int d[8], input bit diff, input bit transp);
        int mods[8][2] = '{'{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
                           '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}};
        int c[2][3];
        int v, b0, b1, lo, hi, s, lsb, msb, m, a;
        for (int ch = 0; ch < 3; ch++) begin
            v = d[ch];
            if (diff) begin
                b0 = v & 'hf8;
                b1 = (b0 + ((v & 3) << 3) + 256 - ((v & 4) << 3)) & 'hf8;
                c[0][ch] = b0 | (b0 >> 5);
                c[1][ch] = b1 | (b1 >> 5);
            end else begin
                c[0][ch] = (v & 'hf0) | (v >> 4);
                c[1][ch] = ((v & 'h0f) << 4) | (v & 'h0f);
            end
        end
        lo = (d[6] << 8) | d[7];
        hi = (d[4] << 8) | d[5];
        for (int i = 0; i < 16; i++) begin
            s = (d[3] & 1) ? ((i >> 1) & 1) : (i >> 3);
            lsb = (lo >> i) & 1;
            msb = (hi >> i) & 1;
            m = mods[s ? (d[3] >> 2) & 7 : (d[3] >> 5) & 7][lsb];
            a = 255;
            if (transp && !lsb) begin
                m = 0;
                if (msb) a = 0;
            end
            if (msb) m = -m;
            paint_px(i, c[s][0] + m, c[s][1] + m, c[s][2] + m, a);
        end
    endfunction

    function automatic void decode_th(input int d[8], input bit hmode, input bit transp);
        int dists[8] = '{3, 6, 11, 16, 23, 32, 41, 64};
        int c[2][3];
        int pal[4][3];
        int th_dist, r1, g1, b1, r2, g2, b2, di, lo, hi, idx;
        if (!hmode) begin
            r1 = ((d[0] >> 1) & 'h0c) | (d[0] & 3);
            c[0][0] = (r1 << 4) | r1;
            c[0][1] = (d[1] & 'hf0) | (d[1] >> 4);
            c[0][2] = ((d[1] & 'h0f) << 4) | (d[1] & 'h0f);
            c[1][0] = (d[2] & 'hf0) | (d[2] >> 4);
            c[1][1] = ((d[2] & 'h0f) << 4) | (d[2] & 'h0f);
            c[1][2] = (d[3] & 'hf0) | (d[3] >> 4);
            th_dist = dists[((d[3] >> 1) & 6) | (d[3] & 1)];
            for (int ch = 0; ch < 3; ch++) begin
                pal[0][ch] = c[0][ch];
                pal[1][ch] = c[1][ch] + th_dist;
                pal[2][ch] = c[1][ch];
                pal[3][ch] = c[1][ch] - th_dist;
            end
        end else begin
            r1 = (d[0] >> 3) & 'h0f;
            g1 = ((d[0] & 7) << 1) | ((d[1] >> 4) & 1);
            b1 = (d[1] & 8) | ((d[1] & 3) << 1) | (d[2] >> 7);
            r2 = (d[2] >> 3) & 'h0f;
            g2 = ((d[2] & 7) << 1) | (d[3] >> 7);
            b2 = (d[3] >> 3) & 'h0f;
            di = (d[3] & 4) | ((d[3] & 1) << 1);
            // The ordering of the two base colors supplies the distance LSB.
            if (((r1 << 8) | (g1 << 4) | b1) >= ((r2 << 8) | (g2 << 4) | b2)) di++;
            th_dist = dists[di & 7];
            c[0] = '{r1 * 17, g1 * 17, b1 * 17};
            c[1] = '{r2 * 17, g2 * 17, b2 * 17};
            for (int ch = 0; ch < 3; ch++) begin
                pal[0][ch] = c[0][ch] + th_dist;
                pal[1][ch] = c[0][ch] - th_dist;
                pal[2][ch] = c[1][ch] + th_dist;
                pal[3][ch] = c[1][ch] - th_dist;
            end
        end
        lo = (d[6] << 8) | d[7];
        hi = (d[4] << 8) | d[5];
        for (int i = 0; i < 16; i++) begin
            idx = (((hi >> i) & 1) << 1) | ((lo >> i) & 1);
            paint_px(i, pal[idx][0], pal[idx][1], pal[idx][2],
                     (transp && idx == 2) ? 0 : 255);
        end
    endfunction

    function automatic int plane(input int o, input int h, input int v, input int x,
                                 input int y);
        int s;
        s = x * (h - o) + y * (v - o) + 4 * o + 2;
        return s < 0 ? 0 : clamp8(s / 4);
    endfunction

    function automatic void decode_planar(input int d[8]);
        int ro, go, bo, rh, gh, bh, rv, gv, bv;
        ro = ((d[0] << 1) & 'hfc) | ((d[0] >> 5) & 3);
        go = ((d[0] & 1) << 7) | (d[1] & 'h7e) | (d[0] & 1);
        bo = ((d[1] & 1) << 7) | ((d[2] << 2) & 'h60) | ((d[2] << 3) & 'h18)
             | ((d[3] >> 5) & 4);
        bo = bo | (bo >> 6);
        rh = ((d[3] << 1) & 'hf8) | ((d[3] << 2) & 4) | ((d[3] >> 5) & 3);
        gh = (d[4] & 'hfe) | (d[4] >> 7);
        bh = ((d[4] & 1) << 7) | ((d[5] >> 1) & 'h7c);
        bh = bh | (bh >> 6);
        rv = ((d[5] << 5) & 'he0) | ((d[6] >> 3) & 'h1c) | ((d[5] >> 1) & 3);
        gv = ((d[6] << 3) & 'hf8) | ((d[7] >> 5) & 6) | ((d[6] >> 4) & 1);
        bv = ((d[7] << 2) & 'hfc) | ((d[7] >> 4) & 3);
        for (int y = 0; y < 4; y++) begin
            for (int x = 0; x < 4; x++) begin
                img[y * 4 + x][0] = plane(ro, rh, rv, x, y);
                img[y * 4 + x][1] = plane(go, gh, gv, x, y);
                img[y * 4 + x][2] = plane(bo, bh, bv, x, y);
                img[y * 4 + x][3] = 255;
            end
        end
    endfunction

    function automatic int base_sum(input int v);
        return (v & 'hf8) + ((v & 3) << 3) - ((v & 4) << 3);
    endfunction

    // Decodes one block and queues its sixteen pixels.
    function automatic void expect_block(input logic [63:0] w, input etc2_pkg::fmt_t fmt);
        int d[8];
        bit diffbit, transp;
        pixel_t px;
        for (int i = 0; i < 8; i++) d[i] = int'(w[63 - 8 * i -: 8]);
        diffbit = d[3][1];
        transp = (fmt == etc2_pkg::FMT_PUNCH) && !diffbit;
        if (fmt == etc2_pkg::FMT_ETC1) decode_base(d, diffbit, 1'b0);
        else if (fmt != etc2_pkg::FMT_PUNCH && !diffbit) decode_base(d, 1'b0, 1'b0);
        else if (base_sum(d[0]) < 0 || base_sum(d[0]) > 255) decode_th(d, 1'b0, transp);
        else if (base_sum(d[1]) < 0 || base_sum(d[1]) > 255) decode_th(d, 1'b1, transp);
        else if (base_sum(d[2]) < 0 || base_sum(d[2]) > 255) decode_planar(d);
        else decode_base(d, 1'b1, transp);
        for (int p = 0; p < 16; p++) begin
            px.idx   = 4'(p);
            px.red   = 8'(img[p][0]);
            px.green = 8'(img[p][1]);
            px.blue  = 8'(img[p][2]);
            px.alpha = 8'(img[p][3]);
            px.last  = (p == 15);
            pixel_q.push_back(px);
        end
    endfunction

    // An overflowing 5-bit base: either above 31 or below 0 after the delta.
    function automatic logic [7:0] overflow_byte();
        if ($urandom_range(0, 1)) return {5'd31 - 5'($urandom_range(0, 2)), 3'd3};
        return {5'($urandom_range(0, 3)), 3'b100};
    endfunction

    function automatic logic [63:0] random_block();
        logic [7:0] d[8];
        for (int i = 0; i < 8; i++) d[i] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            1: d[0] = overflow_byte();
            2: begin
                d[0] = d[0] & 8'h7b;
                d[1] = overflow_byte();
            end
            3: begin
                d[0] = d[0] & 8'h7b;
                d[1] = d[1] & 8'h7b;
                d[2] = overflow_byte();
            end
            4: begin
                d[0] = d[0] & 8'h7b;
                d[1] = d[1] & 8'h7b;
                d[2] = d[2] & 8'h7b;
            end
            default: ;
        endcase
        return {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7]};
    endfunction

    // Input side: one transaction per queued block, random gaps between them.
    always @(posedge aclk) begin
        logic nxt_valid;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end else begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expect_block(s_axis_tdata, cur_fmt);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (block_q.size() > 0) begin
                    nxt_valid = 1'b1;
                    s_axis_tdata <= block_q.pop_front();
                    send_gap <= $urandom_range(0, 6);
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // Output side: compare each pixel transaction, stall at random between them.
    always @(posedge aclk) begin
        pixel_t want;
        int nxt_gap;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            nxt_gap = recv_gap;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected pixel index", m_axis_tdata[3:0], 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_axis_tdata[3:0] != want.idx)
                        report_mismatch("pixel_index", m_axis_tdata[3:0], want.idx);
                    if (m_axis_tdata[11:4] != want.red)
                        report_mismatch("red", m_axis_tdata[11:4], want.red);
                    if (m_axis_tdata[19:12] != want.green)
                        report_mismatch("green", m_axis_tdata[19:12], want.green);
                    if (m_axis_tdata[27:20] != want.blue)
                        report_mismatch("blue", m_axis_tdata[27:20], want.blue);
                    if (m_axis_tdata[35:28] != want.alpha)
                        report_mismatch("alpha", m_axis_tdata[35:28], want.alpha);
                    if (m_axis_tlast != want.last)
                        report_mismatch("last_pixel", m_axis_tlast, want.last);
                end
                nxt_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else if (nxt_gap > 0) begin
                nxt_gap = nxt_gap - 1;
            end
            recv_gap <= nxt_gap;
            m_axis_tready <= (nxt_gap == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cur_fmt = etc2_pkg::FMT_ETC2;
        err_count = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (fmt_seq[ph]) begin
            // Pause the sender until the decoder has drained completely.
            while (block_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0)
                @(posedge aclk);
            repeat (8) @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data <= fmt_seq[ph];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cur_fmt = fmt_seq[ph];
            cfg_valid <= 1'b0;
            if (ph == 1 || ph == 2)
                foreach (directed[i]) block_q.push_back(directed[i]);
            for (int i = 0; i < RANDOM_PER_FMT; i++) block_q.push_back(random_block());
        end
        while (block_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
